// ===== rtl/dtw_pkg.sv =====
// dtw_pkg: shared constants and codes for the dynamic time warping cost block
// no dependencies; imported by the top module, the divider and the checker (not by dtw_ram)

package dtw_pkg;

  localparam int REF_DEPTH   = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int ADDR_W      = $clog2(REF_DEPTH);
  localparam int LEN_W       = $clog2(REF_DEPTH + 1);
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int COST_W      = 48;
  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam int FRAC_BITS   = 8;

  localparam int QLEN_W      = 32;
  localparam int DEN_W       = QLEN_W + 1;
  localparam int DIVIDEND_W  = COST_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

  localparam int STATUS_W    = 2;
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_REF = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TRUNC  = 2'd2;

  localparam logic OP_REF   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_NORM_ADDR = 3'd0;

endpackage

// ===== rtl/dtw_scalar_sequence_cost_top.sv =====
// dtw_scalar_sequence_cost_top: dynamic time warping cost over a stored reference
// depends on dtw_pkg, dtw_ram (reference store, cost column) and dtw_div
//
// A reference sample (tuser 0) is stored; a reference sample after a
// query or after a closed reference starts a new reference. A query sample
// (tuser 1) sweeps the cost-column memory once, one reference entry per cycle. On
// the query sample marked tlast the final cost leaves on the out channel; with
// normalisation on, it passes through the restoring divider first. No clearing
// pass follows reset.

module dtw_scalar_sequence_cost_top
  import dtw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // [15:0] sample
  input  logic [0:0]           in_tuser,   // [0] operation
  input  logic                 in_tlast,   // is_last
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [COST_W-1:0]    out_tdata,  // [47:0] path_cost
  output logic [STATUS_W-1:0]  out_tuser,  // [1:0] status
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  typedef enum logic [1:0] {S_IDLE, S_SWEEP, S_DIV, S_EMIT} state_t;

  state_t state_r;

  logic               ref_len_nxt_en;
  logic [LEN_W-1:0]   ref_len_r;
  logic [LEN_W-1:0]   eff_len;
  logic               ref_full;
  logic               ovf_r;
  logic               closed_r;
  logic [QLEN_W-1:0]  qlen_r;
  logic [QLEN_W-1:0]  qlen_nxt;
  logic               norm_r;

  logic               in_acc;
  logic               ref_acc;
  logic               qry_acc;
  logic               cfg_wr;

  logic signed [SAMPLE_BITS-1:0] s_r;
  logic               last_r;
  logic               first_r;
  logic [LEN_W-1:0]   n_r;
  logic [DEN_W-1:0]   den_r;

  logic [LEN_W-1:0]   rd_idx_r;
  logic               issue;
  logic               p_vld_r;
  logic [ADDR_W-1:0]  p_idx_r;
  logic [COST_W-1:0]  diag_r;
  logic [COST_W-1:0]  below_r;

  logic [SAMPLE_BITS-1:0] ref_rd;
  logic [COST_W-1:0]  cost_rd;
  logic [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]  local_d;
  logic [COST_W-1:0]  m_dl;
  logic [COST_W-1:0]  m3;
  logic [COST_W-1:0]  base;
  logic [COST_W:0]    sum;
  logic [COST_W-1:0]  cell_cost;
  logic               sweep_done;

  logic               div_start;
  logic               div_done;
  logic [DIVIDEND_W-1:0] div_q;

  logic [COST_W-1:0]   res_cost_r;
  logic [STATUS_W-1:0] res_status_r;
  logic                out_tvalid_r;
  logic [COST_W-1:0]   out_tdata_r;
  logic [STATUS_W-1:0] out_tuser_r;
  logic                out_free;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ref_acc   = in_acc && (in_tuser[0] == OP_REF);
  assign qry_acc   = in_acc && (in_tuser[0] == OP_QUERY);

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_NORM_ADDR) ? {{(PDATA_W-1){1'b0}}, norm_r} : '0;

  // reference bookkeeping
  assign eff_len        = closed_r ? '0 : ref_len_r;
  assign ref_full       = (eff_len == LEN_W'(REF_DEPTH));
  assign ref_len_nxt_en = ref_acc && !ref_full;
  assign qlen_nxt       = (qlen_r == '1) ? qlen_r : qlen_r + QLEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_len_r <= '0;
      ovf_r     <= 1'b0;
      closed_r  <= 1'b1;
      qlen_r    <= '0;
      norm_r    <= 1'b0;
    end else begin
      if (cfg_wr && paddr == REG_NORM_ADDR) begin
        norm_r <= pwdata[0];
      end
      if (ref_acc) begin
        ref_len_r <= ref_full ? eff_len : eff_len + LEN_W'(1);
        ovf_r     <= (closed_r ? 1'b0 : ovf_r) | ref_full;
        closed_r  <= in_tlast;
        if (closed_r) begin
          qlen_r <= '0;
        end
      end else if (qry_acc) begin
        closed_r <= 1'b1;
        qlen_r   <= in_tlast ? '0 : qlen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (qry_acc) begin
      s_r     <= in_tdata[SAMPLE_BITS-1:0];
      last_r  <= in_tlast;
      first_r <= (qlen_r == '0);
      n_r     <= ref_len_r;
      den_r   <= DEN_W'(ref_len_r) + DEN_W'(qlen_nxt);
    end
  end

  dtw_ram #(.DEPTH(REF_DEPTH), .WIDTH(SAMPLE_BITS)) u_ref_ram (
    .clk   (clk),
    .we    (ref_len_nxt_en),
    .waddr (eff_len[ADDR_W-1:0]),
    .wdata (in_tdata[SAMPLE_BITS-1:0]),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (ref_rd)
  );

  dtw_ram #(.DEPTH(REF_DEPTH), .WIDTH(COST_W)) u_cost_ram (
    .clk   (clk),
    .we    (p_vld_r),
    .waddr (p_idx_r),
    .wdata (cell_cost),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (cost_rd)
  );

  // column sweep: read entry i while entry i-1 is written back
  assign issue = (state_r == S_SWEEP) && (rd_idx_r < n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (qry_acc) begin
      rd_idx_r <= '0;
    end else if (issue) begin
      rd_idx_r <= rd_idx_r + LEN_W'(1);
    end
    p_idx_r <= rd_idx_r[ADDR_W-1:0];
    if (p_vld_r) begin
      below_r <= cell_cost;
      diag_r  <= cost_rd;
    end
  end

  always_comb begin
    diff    = DIFF_W'($signed(ref_rd)) - DIFF_W'(s_r);
    local_d = diff[DIFF_W-1] ? DIFF_W'(-diff) : diff;
    m_dl    = (diag_r < cost_rd) ? diag_r : cost_rd;
    m3      = (m_dl < below_r) ? m_dl : below_r;
    if (p_idx_r == '0) begin
      base = first_r ? '0 : cost_rd;
    end else begin
      base = first_r ? below_r : m3;
    end
    sum       = {1'b0, base} + (COST_W+1)'(local_d);
    cell_cost = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
  end

  assign sweep_done = p_vld_r && (LEN_W'(p_idx_r) == n_r - LEN_W'(1));
  assign div_start  = (state_r == S_SWEEP) && sweep_done && last_r && norm_r;

  dtw_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({cell_cost, {FRAC_BITS{1'b0}}}),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (qry_acc) begin
            if (ref_len_r == '0) begin
              if (in_tlast) begin
                res_cost_r   <= '0;
                res_status_r <= STATUS_NO_REF;
                state_r      <= S_EMIT;
              end
            end else begin
              state_r <= S_SWEEP;
            end
          end
        end
        S_SWEEP: begin
          if (sweep_done) begin
            res_status_r <= ovf_r ? STATUS_TRUNC : STATUS_OK;
            res_cost_r   <= cell_cost;
            if (!last_r) begin
              state_r <= S_IDLE;
            end else if (norm_r) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            res_cost_r <= (|div_q[DIVIDEND_W-1:COST_W]) ? COST_MAX : div_q[COST_W-1:0];
            state_r    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_tdata_r  <= res_cost_r;
            out_tuser_r  <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

// ===== rtl/dtw_ram.sv =====
// dtw_ram: simple dual-port synchronous ram, one write and one registered read port
// no dependencies; holds the reference samples and the cost column

module dtw_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/dtw_div.sv =====
// dtw_div: restoring divider, one quotient bit per cycle, for the normalised cost
// depends on dtw_pkg

module dtw_div
  import dtw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DEN_W-1:0]      divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DEN_W-1:0]      rem_r;
  logic [DEN_W-1:0]      den_r;
  logic [DIVIDEND_W-1:0] quo_r;
  logic [DEN_W:0]        trial;
  logic                  ge;
  logic [DEN_W-1:0]      rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIVIDEND_W-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !start && (cnt_r == DIV_CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIVIDEND_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/dtw_chk.sv =====
// dtw_chk: port-level checks for the dynamic time warping cost block
// depends on dtw_pkg; bound to dtw_scalar_sequence_cost_top

module dtw_chk
  import dtw_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [COST_W-1:0]   out_tdata,
  input logic [STATUS_W-1:0] out_tuser
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == STATUS_OK || out_tuser == STATUS_NO_REF ||
                    out_tuser == STATUS_TRUNC))
    else $error("unknown status code");

  a_no_ref_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STATUS_NO_REF |-> out_tdata == '0)
    else $error("cost without reference not zero");

endmodule

bind dtw_scalar_sequence_cost_top dtw_chk u_dtw_chk (.*);
